@@ hw/rtl/pdc_pkg.sv @@
// shared types and constants for the projective depth correspondence block
package pdc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MATCH = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  localparam logic [2:0] REG_X_UV    = 3'd0;
  localparam logic [2:0] REG_X_CONST = 3'd1;
  localparam logic [2:0] REG_Y_UV    = 3'd2;
  localparam logic [2:0] REG_Y_CONST = 3'd3;
  localparam logic [2:0] REG_Z_UV    = 3'd4;
  localparam logic [2:0] REG_Z_CONST = 3'd5;
  localparam logic [2:0] REG_MAX_GAP = 3'd6;

  // warped row values stay below 2^59 in magnitude
  localparam int unsigned RW = 61;
  localparam int unsigned QW = 62;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DIV,
    ST_RND,
    ST_RDREF,
    ST_CHECK,
    ST_RDTAB,
    ST_DONE,
    ST_CLEAR
  } state_e;

endpackage

@@ hw/rtl/projective_depth_correspondence.sv @@
// top level: warp datapath, serial divider, reference and correspondence memories
// each op ends in a done_o strobe; a match divides x and y by z in the 61-bit serial divider
// a match ends early for an unusable pixel, for nonpositive depth, or off the frame
// clear sweeps the table one entry per cycle
// one op at a time, the next is accepted in the strobe cycle; no stall
// reset: identity warp, max gap 70, count 0, then a silent table sweep
module projective_depth_correspondence
  import pdc_pkg::*;
#(
  parameter int unsigned IMG_WIDTH  = 640,
  parameter int unsigned IMG_HEIGHT = 480
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic [1:0]  op_i,
  input  logic [9:0]  pix_x_i,
  input  logic [8:0]  pix_y_i,
  input  logic [15:0] depth_mm_i,
  input  logic        pix_valid_i,
  output logic        done_o,
  output logic        hit_o,
  output logic        in_frame_o,
  output logic [9:0]  target_x_o,
  output logic [8:0]  target_y_o,
  output logic [18:0] match_count_o
);

  localparam int unsigned NPIX = IMG_WIDTH * IMG_HEIGHT;
  localparam int unsigned AW   = $clog2(NPIX);
  localparam int unsigned CNTW = $clog2(NPIX + 1);
  localparam int unsigned ZW   = 59;
  localparam int unsigned EW   = 10 + 9 + ZW;

  state_e state_q, state_d;

  logic [63:0] reg_q [6];
  logic [15:0] gap_lim_q;

  // input capture
  op_e         op_q;
  logic [9:0]  px_q;
  logic [8:0]  py_q;
  logic [15:0] dep_q;
  logic        pv_q;
  logic        in_img;
  logic [AW-1:0] in_addr;

  // warp pipeline
  logic signed [RW-1:0] rx_q, ry_q, rz_q;
  logic signed [RW-1:0] s_prod;
  logic [1:0]           row_q;
  logic signed [63:0]   m_u, m_v;
  logic signed [42:0]   sum_s;
  logic signed [31:0]   cu, cv, cc, ct;

  logic signed [QW-1:0] u0_q, v0_q, quot;
  logic                 div_sel_q;
  logic                 div_start, div_done;
  logic signed [RW-1:0] div_num;

  logic [AW-1:0]  tgt_addr_q;
  logic           tgt_ok_q;

  // memories; table entry is {valid, source col, source row, depth}
  logic [15:0]    ref_mem [NPIX];
  logic [15:0]    ref_rd_q;
  logic [EW:0]    tab_mem [NPIX];
  logic [EW:0]    tab_rd_q;
  logic           tab_we, ref_we;
  logic [AW-1:0]  tab_wa, tab_ra;
  logic [EW:0]    tab_wd;
  logic           tab_re;

  logic [CNTW-1:0] clr_q;
  logic [18:0]     count_q;
  logic            init_q;
  logic            res_hit_q, res_inf_q;
  logic [9:0]      res_x_q;
  logic [8:0]      res_y_q;
  logic            done_q;

  logic signed [RW+1:0] gap;
  logic signed [RW+1:0] lim;
  logic                  accept_hit;

  assign in_img  = (32'(pix_x_i) < IMG_WIDTH) && (32'(pix_y_i) < IMG_HEIGHT);
  assign in_addr = AW'(32'(pix_y_i) * IMG_WIDTH + 32'(pix_x_i));

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q[0]  <= 64'd16777216;
      reg_q[1]  <= '0;
      reg_q[2]  <= 64'd72057594037927936;
      reg_q[3]  <= '0;
      reg_q[4]  <= '0;
      reg_q[5]  <= 64'd16777216;
      gap_lim_q <= 16'd70;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_UV, REG_X_CONST, REG_Y_UV, REG_Y_CONST, REG_Z_UV, REG_Z_CONST: begin
          reg_q[cfg_idx_i] <= cfg_data_i;
        end
        REG_MAX_GAP: gap_lim_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // one row per pass: products registered, then scaled by depth
  always_comb begin
    cu = $signed(reg_q[{row_q, 1'b0}][31:0]);
    cv = $signed(reg_q[{row_q, 1'b0}][63:32]);
    cc = $signed(reg_q[{row_q, 1'b1}][31:0]);
    ct = $signed(reg_q[{row_q, 1'b1}][63:32]);
  end

  logic signed [63:0] mu_q, mv_q;
  assign m_u   = cu * $signed({1'b0, 22'd0, px_q});
  assign m_v   = cv * $signed({1'b0, 23'd0, py_q});
  assign sum_s = 43'(mu_q) + 43'(mv_q) + 43'(cc);
  assign s_prod = RW'(sum_s * $signed({1'b0, dep_q})) + RW'(ct * 64'sd65536);

  // the second divide starts in the cycle the first one reports done
  assign div_num = (div_sel_q || div_done) ? ry_q : rx_q;

  pdc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (rz_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign gap = $signed({2'b0, rz_q}) - $signed({1'b0, 22'd0, ref_rd_q, 24'd0});
  assign lim = $signed({1'b0, 22'd0, gap_lim_q, 24'd0});
  assign accept_hit = (ref_rd_q != '0) && (gap <= lim) && (-gap <= lim) &&
                      (!tab_rd_q[EW] || (rz_q <= $signed({2'b0, tab_rd_q[ZW-1:0]})));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start && !busy) begin
          case (op_e'(op_i))
            OP_LOAD:  state_d = ST_DONE;
            OP_MATCH: state_d = ST_MUL1;
            OP_READ:  state_d = ST_RDTAB;
            default:  state_d = ST_CLEAR;
          endcase
        end
      end
      ST_MUL1:  state_d = (dep_q == '0 || !pv_q) ? ST_DONE : ST_MUL2;
      ST_MUL2:  state_d = ST_MUL3;
      ST_MUL3:  state_d = (row_q == 2'd2) ? ST_DIV : ST_MUL2;
      ST_DIV: begin
        if (rz_q <= 0) state_d = ST_DONE;
        else if (div_done && div_sel_q) state_d = ST_RND;
      end
      ST_RND:   state_d = tgt_ok_q ? ST_RDREF : ST_DONE;
      ST_RDREF: state_d = ST_CHECK;
      ST_CHECK: state_d = ST_DONE;
      ST_RDTAB: state_d = ST_DONE;
      ST_CLEAR: begin
        // the sweep after reset ends without a result beat
        if (clr_q == CNTW'(NPIX)) state_d = init_q ? ST_IDLE : ST_DONE;
      end
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy = (state_q != ST_IDLE);
    div_start = 1'b0;
    ref_we = 1'b0;
    tab_we = 1'b0;
    tab_wa = tgt_addr_q;
    tab_wd = {1'b1, px_q, py_q, ZW'(rz_q)};
    tab_ra = tgt_addr_q;
    tab_re = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start && op_e'(op_i) == OP_LOAD && in_img) ref_we = 1'b1;
        tab_ra = in_addr;
        tab_re = start && (op_e'(op_i) == OP_READ);
      end
      ST_DIV: begin
        // row_q still 3 only in the first divide cycle, once rz_q is loaded
        div_start = ((row_q == 2'd3) && (rz_q > 0)) || (div_done && !div_sel_q);
      end
      ST_RDREF: tab_re = 1'b1;
      ST_CHECK: tab_we = accept_hit;
      ST_CLEAR: begin
        tab_we = (clr_q != CNTW'(NPIX));
        tab_wa = clr_q[AW-1:0];
        tab_wd = '0;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (ref_we) ref_mem[in_addr] <= depth_mm_i;
    ref_rd_q <= ref_mem[tgt_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    if (tab_re) tab_rd_q <= tab_mem[tab_ra];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
      row_q     <= '0;
      div_sel_q <= 1'b0;
      tgt_ok_q  <= 1'b0;
      init_q    <= 1'b1;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_DONE);
      case (state_q)
        ST_IDLE: begin
          row_q     <= '0;
          div_sel_q <= 1'b0;
          clr_q     <= '0;
          tgt_ok_q  <= 1'b0;
          init_q    <= 1'b0;
        end
        ST_MUL3:  row_q <= row_q + 2'd1;
        ST_DIV: begin
          row_q <= '0;
          if (div_done) div_sel_q <= 1'b1;
        end
        ST_CHECK: if (accept_hit && !tab_rd_q[EW]) count_q <= count_q + 19'd1;
        ST_CLEAR: begin
          if (clr_q != CNTW'(NPIX)) clr_q <= clr_q + 1'b1;
          count_q <= '0;
        end
        default: ;
      endcase
      if (state_q == ST_DIV && div_done && div_sel_q) begin
        tgt_ok_q <= (u0_q >= 0) && (u0_q < QW'(IMG_WIDTH)) &&
                    (quot >= 0) && (quot < QW'(IMG_HEIGHT));
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      op_q  <= op_e'(op_i);
      px_q  <= pix_x_i;
      py_q  <= pix_y_i;
      dep_q <= depth_mm_i;
      pv_q  <= pix_valid_i;
      res_hit_q <= 1'b0;
      res_inf_q <= 1'b0;
      res_x_q   <= '0;
      res_y_q   <= '0;
    end
    mu_q <= m_u;
    mv_q <= m_v;
    if (state_q == ST_MUL3) begin
      case (row_q)
        2'd0:    rx_q <= s_prod;
        2'd1:    ry_q <= s_prod;
        default: rz_q <= s_prod;
      endcase
    end
    if (state_q == ST_DIV && div_done) begin
      if (!div_sel_q) u0_q <= quot;
      else            v0_q <= quot;
    end
    if (state_q == ST_RND) begin
      tgt_addr_q <= AW'(32'(v0_q[11:0]) * IMG_WIDTH + 32'(u0_q[11:0]));
      if (tgt_ok_q) begin
        res_inf_q <= 1'b1;
        res_x_q   <= u0_q[9:0];
        res_y_q   <= v0_q[8:0];
      end
    end
    if (state_q == ST_CHECK) res_hit_q <= accept_hit;
    if (state_q == ST_RDTAB && op_q == OP_READ) begin
      if ((32'(px_q) < IMG_WIDTH) && (32'(py_q) < IMG_HEIGHT) && tab_rd_q[EW]) begin
        res_hit_q <= 1'b1;
        res_x_q   <= tab_rd_q[EW-1 -: 10];
        res_y_q   <= tab_rd_q[EW-11 -: 9];
      end
    end
  end

  assign done_o        = done_q;
  assign hit_o         = res_hit_q;
  assign in_frame_o    = res_inf_q;
  assign target_x_o    = res_x_q;
  assign target_y_o    = res_y_q;
  assign match_count_o = count_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("result strobe outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tab_we |-> (state_q == ST_CHECK || state_q == ST_CLEAR))
    else $error("table write outside check or clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> count_q == '0)
    else $error("count not cleared by sweep");

endmodule

@@ hw/rtl/pdc_div.sv @@
// restoring divider, one quotient bit per cycle, rounds to nearest even
module pdc_div
  import pdc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [RW-1:0] num_i,
  input  logic signed [RW-1:0] den_i,
  output logic                 done_o,
  output logic signed [QW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(RW + 1);

  logic [RW-1:0]  mag_q, mag_d;
  logic [RW-1:0]  den_q, den_d;
  logic [RW:0]    rem_q, rem_d;
  logic           neg_q, neg_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           run_q, run_d;
  logic           done_q, done_d;
  logic signed [QW-1:0] quot_q, quot_d;
  logic [RW:0]    trial;
  logic [RW:0]    rem_sh;
  logic signed [QW-1:0] qs;
  logic [RW+1:0]  twice;
  logic           up;

  assign rem_sh = {rem_q[RW-1:0], mag_q[RW-1]};
  assign trial  = rem_sh - {1'b0, den_q};

  always_comb begin
    mag_d  = mag_q;
    den_d  = den_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    quot_d = quot_q;
    qs     = '0;
    twice  = '0;
    up     = 1'b0;
    if (start_i) begin
      neg_d = num_i[RW-1];
      mag_d = num_i[RW-1] ? RW'(-num_i) : RW'(num_i);
      den_d = RW'(den_i);
      rem_d = '0;
      cnt_d = CW'(RW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (cnt_q != '0) begin
        mag_d = {mag_q[RW-2:0], ~trial[RW]};
        rem_d = trial[RW] ? rem_sh : trial;
        cnt_d = cnt_q - 1'b1;
      end else begin
        // floor quotient and nonnegative remainder from magnitude result
        if (neg_q && rem_q != '0) begin
          qs = -$signed(QW'(mag_q)) - $signed(QW'(1));
          rem_d = {1'b0, den_q} - rem_q;
        end else begin
          qs = neg_q ? -$signed(QW'(mag_q)) : $signed(QW'(mag_q));
          rem_d = rem_q;
        end
        twice = {rem_d, 1'b0};
        up = (twice > {2'b0, den_q}) || ((twice == {2'b0, den_q}) && qs[0]);
        quot_d = qs + $signed(QW'(up));
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
